// ===== sv/kmc_pkg.sv =====
// Shared constants, codes and the character series lookup for the multi-tap entry block.
// Used by the interfaces, the register port and the core; depends on nothing.
package kmc_pkg;

   // Field widths.
   localparam int ACTION_W = 3;
   localparam int KEY_W    = 4;
   localparam int TIME_W   = 32;
   localparam int POS_W    = 5;
   localparam int CHAR_W   = 7;
   localparam int MODE_W   = 2;
   localparam int TMO_W    = 16;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_TIMEOUT = 1'b0;
   localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd1000;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_DIGIT   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_SHIFT   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_CAPS    = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_SYMBOLS = 3'd4;

   // Letter modes.
   localparam logic [MODE_W-1:0] MODE_LOWER   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CAPS    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SYMBOLS = 2'd2;

   localparam logic [KEY_W-1:0]  KEY_MAX     = 4'd9;
   localparam logic [CHAR_W-1:0] CASE_OFFSET = 7'd32;
   localparam logic [CHAR_W-1:0] ASCII_UC_A  = 7'h41;
   localparam logic [CHAR_W-1:0] ASCII_UC_Z  = 7'h5A;
   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;

   // Number of characters in each key's series.
   function automatic logic [POS_W-1:0] series_len(input logic [KEY_W-1:0] key);
      logic [POS_W-1:0] len;
      case (key)
         4'd0:    len = 5'd21;
         4'd1:    len = 5'd14;
         4'd7:    len = 5'd5;
         4'd9:    len = 5'd5;
         default: len = 5'd4;
      endcase
      return len;
   endfunction

   // First letter of a letter key (keys two to nine).
   function automatic logic [CHAR_W-1:0] letter_base(input logic [KEY_W-1:0] key);
      logic [CHAR_W-1:0] base;
      case (key)
         4'd2:    base = 7'h41;
         4'd3:    base = 7'h44;
         4'd4:    base = 7'h47;
         4'd5:    base = 7'h4A;
         4'd6:    base = 7'h4D;
         4'd7:    base = 7'h50;
         4'd8:    base = 7'h54;
         default: base = 7'h57;
      endcase
      return base;
   endfunction

   // Punctuation series of key zero.
   function automatic logic [CHAR_W-1:0] key0_char(input logic [POS_W-1:0] pos);
      logic [CHAR_W-1:0] ch;
      case (pos)
         5'd0:    ch = 7'h20;
         5'd1:    ch = 7'h21;
         5'd2:    ch = 7'h40;
         5'd3:    ch = 7'h23;
         5'd4:    ch = 7'h24;
         5'd5:    ch = 7'h25;
         5'd6:    ch = 7'h5E;
         5'd7:    ch = 7'h26;
         5'd8:    ch = 7'h2A;
         5'd9:    ch = 7'h28;
         5'd10:   ch = 7'h29;
         5'd11:   ch = 7'h5B;
         5'd12:   ch = 7'h5D;
         5'd13:   ch = 7'h7B;
         5'd14:   ch = 7'h7D;
         5'd15:   ch = 7'h3C;
         5'd16:   ch = 7'h3E;
         5'd17:   ch = 7'h2F;
         5'd18:   ch = 7'h5C;
         5'd19:   ch = 7'h7C;
         default: ch = 7'h30;
      endcase
      return ch;
   endfunction

   // Punctuation series of key one.
   function automatic logic [CHAR_W-1:0] key1_char(input logic [POS_W-1:0] pos);
      logic [CHAR_W-1:0] ch;
      case (pos)
         5'd0:    ch = 7'h2E;
         5'd1:    ch = 7'h2C;
         5'd2:    ch = 7'h3B;
         5'd3:    ch = 7'h3A;
         5'd4:    ch = 7'h27;
         5'd5:    ch = 7'h22;
         5'd6:    ch = 7'h2D;
         5'd7:    ch = 7'h2B;
         5'd8:    ch = 7'h5F;
         5'd9:    ch = 7'h3D;
         5'd10:   ch = 7'h3F;
         5'd11:   ch = 7'h60;
         5'd12:   ch = 7'h7E;
         default: ch = 7'h31;
      endcase
      return ch;
   endfunction

   // Character at a position of a key's series; the last entry is the digit itself.
   function automatic logic [CHAR_W-1:0] series_char(input logic [KEY_W-1:0] key,
                                                     input logic [POS_W-1:0] pos);
      logic [CHAR_W-1:0] ch;
      case (key)
         4'd0: ch = key0_char(pos);
         4'd1: ch = key1_char(pos);
         default: begin
            if (pos == series_len(key) - 5'd1) begin
               ch = ASCII_ZERO + {3'd0, key};
            end else begin
               ch = letter_base(key) + {2'd0, pos};
            end
         end
      endcase
      return ch;
   endfunction

endpackage

// ===== sv/kmc_if.sv =====
// Valid/ready channel interfaces for key events and result beats.
// Depends on kmc_pkg for field widths.
interface kmc_req_if;
   logic                           valid;
   logic                           ready;
   logic [kmc_pkg::ACTION_W-1:0]   action;
   logic [kmc_pkg::KEY_W-1:0]      key_number;
   logic [kmc_pkg::TIME_W-1:0]     now_ms;

   modport source (output valid, output action, output key_number, output now_ms,
                   input ready);
   modport sink   (input valid, input action, input key_number, input now_ms,
                   output ready);
endinterface

interface kmc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           char_valid;
   logic [kmc_pkg::CHAR_W-1:0]     char_code;
   logic                           replace_last;
   logic                           shift_on;
   logic [kmc_pkg::MODE_W-1:0]     letter_mode;

   modport source (output valid, output char_valid, output char_code,
                   output replace_last, output shift_on, output letter_mode,
                   input ready);
   modport sink   (input valid, input char_valid, input char_code,
                   input replace_last, input shift_on, input letter_mode,
                   output ready);
endinterface

// ===== sv/kmc_csr.sv =====
// APB-style register port holding the repeat timeout.
// Depends on kmc_pkg for the address map and reset value.
module kmc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [kmc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [kmc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [kmc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output logic [kmc_pkg::TMO_W-1:0]      timeout_ms
);

   logic [kmc_pkg::TMO_W-1:0] timeout_ff;
   logic [kmc_pkg::TMO_W-1:0] timeout_in;
   logic                      wr_en;
   logic                      sel_timeout;

   assign csr_pready  = 1'b1;
   assign sel_timeout = (csr_paddr[kmc_pkg::CSR_ADDR_W-1] == kmc_pkg::CSR_IDX_TIMEOUT);
   assign wr_en       = csr_psel && csr_penable && csr_pwrite && sel_timeout;

   // Register write in the access phase.
   always_comb begin
      timeout_in = timeout_ff;
      if (wr_en) begin
         timeout_in = csr_pwdata[kmc_pkg::TMO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= kmc_pkg::TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   // Read back; addresses with the top address bit set read as zero, the others all read the register.
   always_comb begin
      csr_prdata = '0;
      if (sel_timeout) begin
         csr_prdata = {{(kmc_pkg::CSR_DATA_W - kmc_pkg::TMO_W){1'b0}}, timeout_ff};
      end
   end

   assign timeout_ms = timeout_ff;

endmodule

// ===== sv/kmc_core.sv =====
// Multi-tap core: input register, entry state update and result register.
// Depends on kmc_pkg and the channel interfaces in kmc_if.
module kmc_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [kmc_pkg::TMO_W-1:0] timeout_ms,
   kmc_req_if.sink                   req_chan,
   kmc_rsp_if.source                 rsp_chan
);

   // Input stage.
   logic                          s1_valid_ff, s1_valid_in;
   logic [kmc_pkg::ACTION_W-1:0]  s1_action_ff, s1_action_in;
   logic [kmc_pkg::KEY_W-1:0]     s1_key_ff, s1_key_in;
   logic [kmc_pkg::TIME_W-1:0]    s1_now_ff, s1_now_in;

   // Entry state.
   logic                          pending_ff, pending_in;
   logic [kmc_pkg::TIME_W-1:0]    last_time_ff, last_time_in;
   logic [kmc_pkg::KEY_W-1:0]     last_key_ff, last_key_in;
   logic [kmc_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic                          shift_ff, shift_in;
   logic [kmc_pkg::MODE_W-1:0]    mode_ff, mode_in;

   // Result stage.
   logic                          out_valid_ff, out_valid_in;
   logic                          out_cvalid_ff, out_cvalid_in;
   logic [kmc_pkg::CHAR_W-1:0]    out_code_ff, out_code_in;
   logic                          out_replace_ff, out_replace_in;
   logic                          out_shift_ff, out_shift_in;
   logic [kmc_pkg::MODE_W-1:0]    out_mode_ff, out_mode_in;

   logic                          advance;
   logic                          take_req;
   logic [kmc_pkg::TIME_W-1:0]    deadline;
   logic                          timed_out;
   logic                          restart;
   logic [kmc_pkg::POS_W-1:0]     pos_next;
   logic [kmc_pkg::CHAR_W-1:0]    raw_char;
   logic                          upper;

   // The held item moves on when the result register is free or being drained.
   assign advance          = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !s1_valid_ff || advance;
   assign take_req         = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_action_in = s1_action_ff;
      s1_key_in    = s1_key_ff;
      s1_now_in    = s1_now_ff;
      if (take_req) begin
         s1_valid_in  = 1'b1;
         s1_action_in = req_chan.action;
         s1_key_in    = req_chan.key_number;
         s1_now_in    = req_chan.now_ms;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // Timeout test against the last press, wrapping modulo 2^32.
   assign deadline  = last_time_ff + {{(kmc_pkg::TIME_W - kmc_pkg::TMO_W){1'b0}}, timeout_ms};
   assign timed_out = deadline < s1_now_ff;
   assign restart   = !pending_ff || (s1_key_ff != last_key_ff) || timed_out;

   // Next position in the series for a repeat press, wrapping at its end.
   always_comb begin
      pos_next = pos_ff + 5'd1;
      if (pos_next >= kmc_pkg::series_len(s1_key_ff)) begin
         pos_next = '0;
      end
   end

   // State update for the held item.
   always_comb begin
      pending_in     = pending_ff;
      last_time_in   = last_time_ff;
      last_key_in    = last_key_ff;
      pos_in         = pos_ff;
      shift_in       = shift_ff;
      mode_in        = mode_ff;
      out_cvalid_in  = 1'b0;
      out_replace_in = 1'b0;
      case (s1_action_ff)
         kmc_pkg::ACT_DIGIT: begin
            if (s1_key_ff <= kmc_pkg::KEY_MAX) begin
               // A fresh series after a pending press drops shift and symbol mode.
               if (pending_ff && restart) begin
                  shift_in = 1'b0;
                  if (mode_ff == kmc_pkg::MODE_SYMBOLS) begin
                     mode_in = kmc_pkg::MODE_LOWER;
                  end
               end
               pos_in         = restart ? '0 : pos_next;
               out_replace_in = !restart;
               out_cvalid_in  = 1'b1;
               last_key_in    = s1_key_ff;
               last_time_in   = s1_now_ff;
               pending_in     = 1'b1;
            end
         end
         kmc_pkg::ACT_TICK: begin
            if (pending_ff && timed_out) begin
               shift_in   = 1'b0;
               pending_in = 1'b0;
               if (mode_ff == kmc_pkg::MODE_SYMBOLS) begin
                  mode_in = kmc_pkg::MODE_LOWER;
               end
            end
         end
         kmc_pkg::ACT_SHIFT: begin
            shift_in = !shift_ff;
         end
         kmc_pkg::ACT_CAPS: begin
            if (mode_ff == kmc_pkg::MODE_LOWER) begin
               mode_in = kmc_pkg::MODE_CAPS;
            end else if (mode_ff == kmc_pkg::MODE_CAPS) begin
               mode_in = kmc_pkg::MODE_LOWER;
            end
         end
         kmc_pkg::ACT_SYMBOLS: begin
            mode_in = (mode_ff == kmc_pkg::MODE_SYMBOLS) ? kmc_pkg::MODE_LOWER
                                                         : kmc_pkg::MODE_SYMBOLS;
         end
         default: begin
         end
      endcase
   end

   // Character lookup and case folding, using shift and mode after the update.
   assign raw_char = kmc_pkg::series_char(s1_key_ff, pos_in);
   assign upper    = ((mode_in == kmc_pkg::MODE_CAPS) && !shift_in) ||
                     ((mode_in == kmc_pkg::MODE_LOWER) && shift_in);

   always_comb begin
      out_code_in = '0;
      if (out_cvalid_in) begin
         out_code_in = raw_char;
         if (!upper && raw_char >= kmc_pkg::ASCII_UC_A && raw_char <= kmc_pkg::ASCII_UC_Z) begin
            out_code_in = raw_char + kmc_pkg::CASE_OFFSET;
         end
      end
      out_shift_in = shift_in;
      out_mode_in  = mode_in;
   end

   // Result beat valid: set by an advancing item, cleared when taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pending_ff   <= 1'b0;
         last_time_ff <= '0;
         last_key_ff  <= '0;
         pos_ff       <= '0;
         shift_ff     <= 1'b0;
         mode_ff      <= kmc_pkg::MODE_LOWER;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            pending_ff   <= pending_in;
            last_time_ff <= last_time_in;
            last_key_ff  <= last_key_in;
            pos_ff       <= pos_in;
            shift_ff     <= shift_in;
            mode_ff      <= mode_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_action_ff <= s1_action_in;
      s1_key_ff    <= s1_key_in;
      s1_now_ff    <= s1_now_in;
      if (advance) begin
         out_cvalid_ff  <= out_cvalid_in;
         out_code_ff    <= out_code_in;
         out_replace_ff <= out_replace_in;
         out_shift_ff   <= out_shift_in;
         out_mode_ff    <= out_mode_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.char_valid   = out_cvalid_ff;
   assign rsp_chan.char_code    = out_code_ff;
   assign rsp_chan.replace_last = out_replace_ff;
   assign rsp_chan.shift_on     = out_shift_ff;
   assign rsp_chan.letter_mode  = out_mode_ff;

endmodule

// ===== sv/keypad_multitap_char_entry_top.sv =====
// Multi-tap character entry: an accepted event beat passes the input register, then the
// result register, on its way to its result beat; one event is taken every cycle while the
// result register is free or being drained, with the state update between the two registers.
// Synchronous active-high reset clears the entry state to lower case with no pending
// press and loads the timeout register with 1000 ms; no clearing pass is needed.
// Depends on kmc_pkg, kmc_if, kmc_csr and kmc_core.
module keypad_multitap_char_entry_top (
   input  logic                           clock,
   input  logic                           reset,
   kmc_req_if.sink                        req_chan,
   kmc_rsp_if.source                      rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [kmc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [kmc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [kmc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   logic [kmc_pkg::TMO_W-1:0] timeout_ms;

   // Register port.
   kmc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .timeout_ms  (timeout_ms)
   );

   // Entry engine.
   kmc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .timeout_ms (timeout_ms),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the multi-tap character entry block: queued key events
// are driven on the request channel and every result beat is checked against a model.
// Depends on kmc_pkg, kmc_if and keypad_multitap_char_entry_top.
module tb_top;

   localparam int STALL_LIMIT = 4000;
   localparam int LONG_HOLD   = 300;
   localparam int PHASE_ITEMS = 85;
   localparam logic [kmc_pkg::CSR_ADDR_W-1:0] TIMEOUT_ADDR =
      {kmc_pkg::CSR_IDX_TIMEOUT, 2'b00};

   typedef bit [kmc_pkg::ACTION_W-1:0] action_type;
   typedef bit [kmc_pkg::KEY_W-1:0]    key_type;
   typedef bit [kmc_pkg::TMO_W-1:0]    timeout_type;

   // Action codes the block must ignore.
   localparam action_type ACT_SPARE_LO = 3'd5;
   localparam action_type ACT_SPARE_HI = 3'd7;

   typedef struct packed {
      action_type                 action;
      key_type                    key_number;
      bit [kmc_pkg::TIME_W-1:0]   now_ms;
   } key_event_type;

   typedef struct packed {
      bit                         char_valid;
      bit [kmc_pkg::CHAR_W-1:0]   char_code;
      bit                         replace_last;
      bit                         shift_on;
      bit [kmc_pkg::MODE_W-1:0]   letter_mode;
   } entry_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [kmc_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [kmc_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [kmc_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   kmc_req_if req_if();
   kmc_rsp_if rsp_if();

   keypad_multitap_char_entry_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // Key events waiting to be driven and results waiting to be seen.
   key_event_type    pending_keys[$];
   entry_result_type expected_entries[$];

   // Model of the entry state and its timeout register.
   bit                       ent_pending  = 1'b0;
   bit [kmc_pkg::TIME_W-1:0] ent_last_ms  = '0;
   key_type                  ent_last_key = '0;
   bit [kmc_pkg::POS_W-1:0]  ent_pos      = '0;
   bit                       ent_shift    = 1'b0;
   bit [kmc_pkg::MODE_W-1:0] ent_mode     = kmc_pkg::MODE_LOWER;
   timeout_type              ent_timeout  = kmc_pkg::TIMEOUT_RESET;

   int n_errors   = 0;
   int n_queued   = 0;
   int n_sent     = 0;
   int n_checked  = 0;
   int n_digits   = 0;
   int n_repeats  = 0;
   int n_settings = 0;

   bit                       tx_idle = 1'b1;
   bit                       rx_idle = 1'b1;
   bit                       rx_hold_req = 1'b0;
   bit [kmc_pkg::TIME_W-1:0] sim_ms = '0;

   // Character series of each digit key; the last entry is the digit itself.
   function automatic string key_series(input key_type digit);
      case (digit)
         4'd0:    return " !@#$%^&*()[]{}<>/\\|0";
         4'd1:    return ".,;:'\"-+_=?`~1";
         4'd2:    return "ABC2";
         4'd3:    return "DEF3";
         4'd4:    return "GHI4";
         4'd5:    return "JKL5";
         4'd6:    return "MNO6";
         4'd7:    return "PQRS7";
         4'd8:    return "TUV8";
         default: return "WXYZ9";
      endcase
   endfunction

   // The deadline wraps modulo 2^32 and is compared unsigned.
   function automatic bit past_deadline(input bit [kmc_pkg::TIME_W-1:0] at_ms);
      bit [kmc_pkg::TIME_W-1:0] deadline;
      deadline = ent_last_ms + {{(kmc_pkg::TIME_W-kmc_pkg::TMO_W){1'b0}}, ent_timeout};
      return deadline < at_ms;
   endfunction

   function automatic void drop_modifiers();
      ent_shift = 1'b0;
      if (ent_mode == kmc_pkg::MODE_SYMBOLS) ent_mode = kmc_pkg::MODE_LOWER;
      ent_pending = 1'b0;
   endfunction

   // Advances the model by one key event and returns the result beat it must produce.
   function automatic entry_result_type predict_entry(input key_event_type ev);
      entry_result_type r;
      string series;
      int idx;
      bit [7:0] ch;
      bit upper;
      r = '0;
      case (ev.action)
         kmc_pkg::ACT_DIGIT: begin
            if (ev.key_number <= kmc_pkg::KEY_MAX) begin
               if (ent_pending && ev.key_number == ent_last_key &&
                   !past_deadline(ev.now_ms)) begin
                  ent_pos = ent_pos + 5'd1;
                  r.replace_last = 1'b1;
               end else begin
                  if (ent_pending) drop_modifiers();
                  ent_last_key = ev.key_number;
                  ent_pos = '0;
               end
               series = key_series(ev.key_number);
               idx = int'(ent_pos);
               idx = idx % series.len();
               ent_pos = idx[kmc_pkg::POS_W-1:0];
               ent_last_ms = ev.now_ms;
               ent_pending = 1'b1;
               ch = series[idx];
               upper = (ent_mode == kmc_pkg::MODE_CAPS && !ent_shift) ||
                       (ent_mode == kmc_pkg::MODE_LOWER && ent_shift);
               if (!upper && ch >= "A" && ch <= "Z") ch = ch + {1'b0, kmc_pkg::CASE_OFFSET};
               r.char_valid = 1'b1;
               r.char_code = ch[kmc_pkg::CHAR_W-1:0];
            end
         end
         kmc_pkg::ACT_TICK: begin
            if (ent_pending && past_deadline(ev.now_ms)) drop_modifiers();
         end
         kmc_pkg::ACT_SHIFT: ent_shift = !ent_shift;
         kmc_pkg::ACT_CAPS: begin
            if (ent_mode == kmc_pkg::MODE_LOWER) ent_mode = kmc_pkg::MODE_CAPS;
            else if (ent_mode == kmc_pkg::MODE_CAPS) ent_mode = kmc_pkg::MODE_LOWER;
         end
         kmc_pkg::ACT_SYMBOLS: begin
            ent_mode = (ent_mode == kmc_pkg::MODE_SYMBOLS) ? kmc_pkg::MODE_LOWER
                                                           : kmc_pkg::MODE_SYMBOLS;
         end
         default: ;
      endcase
      r.shift_on = ent_shift;
      r.letter_mode = ent_mode;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         n_errors++;
      end
   endtask

   // Driver: one beat per queued event, with a random gap drawn after each one in idling phases.
   key_event_type    tx_item;
   entry_result_type tx_pred;
   bit               tx_busy = 1'b0;
   int               tx_wait = 0;

   always @(posedge clock) begin
      if (reset) begin
         tx_busy = 1'b0;
         tx_wait = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            tx_pred = predict_entry(tx_item);
            expected_entries.push_back(tx_pred);
            n_sent++;
            if (tx_pred.char_valid) n_digits++;
            if (tx_pred.replace_last) n_repeats++;
            tx_busy = 1'b0;
         end
         if (!tx_busy) begin
            if (tx_wait > 0) begin
               tx_wait--;
            end else if (pending_keys.size() != 0) begin
               tx_item = pending_keys.pop_front();
               req_if.action     <= tx_item.action;
               req_if.key_number <= tx_item.key_number;
               req_if.now_ms     <= tx_item.now_ms;
               tx_busy = 1'b1;
               tx_wait = tx_idle ? $urandom_range(0, 12) : 0;
            end
         end
      end
      req_if.valid <= tx_busy;
   end

   // Monitor: checks each result beat, then in idling phases holds ready low for a random number of cycles.
   entry_result_type rx_want;
   int               rx_wait = 0;
   int               rx_hold = 0;
   bit               rx_ready_next;

   always @(posedge clock) begin
      rx_ready_next = 1'b0;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_entries.size() == 0) begin
               $display("%0t: result beat with no event outstanding, expected none, actual %0h",
                        $time, {rsp_if.char_valid, rsp_if.char_code, rsp_if.replace_last,
                                rsp_if.shift_on, rsp_if.letter_mode});
               n_errors++;
            end else begin
               rx_want = expected_entries.pop_front();
               check_field("char_valid", 32'(rx_want.char_valid), 32'(rsp_if.char_valid));
               check_field("char_code", 32'(rx_want.char_code), 32'(rsp_if.char_code));
               check_field("replace_last", 32'(rx_want.replace_last),
                           32'(rsp_if.replace_last));
               check_field("shift_on", 32'(rx_want.shift_on), 32'(rsp_if.shift_on));
               check_field("letter_mode", 32'(rx_want.letter_mode), 32'(rsp_if.letter_mode));
            end
            n_checked++;
            rx_wait = rx_idle ? $urandom_range(0, 12) : 0;
         end
         if (rx_hold_req) begin
            rx_hold = LONG_HOLD;
            rx_hold_req = 1'b0;
         end
         if (rx_hold > 0) rx_hold--;
         else if (rx_wait > 0) rx_wait--;
         else rx_ready_next = 1'b1;
      end
      rsp_if.ready <= rx_ready_next;
   end

   // Watchdog: a long run of cycles with no beat on either channel ends the run.
   int stall_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, stall_cycles, expected_entries.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // One APB transfer on the timeout register; a read is compared with the model.
   task automatic csr_cycle(input bit write, input timeout_type value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= TIMEOUT_ADDR;
      csr_pwdata  <= {{(kmc_pkg::CSR_DATA_W-kmc_pkg::TMO_W){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (write) begin
         ent_timeout = value;
      end else if (csr_prdata[kmc_pkg::TMO_W-1:0] !== ent_timeout) begin
         $display("%0t: timeout_ms readback mismatch, expected %0h, actual %0h",
                  $time, ent_timeout, csr_prdata[kmc_pkg::TMO_W-1:0]);
         n_errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_timeout(input timeout_type value);
      csr_cycle(1'b1, value);
      csr_cycle(1'b0, '0);
      n_settings++;
   endtask

   // Waits until every queued event has been sent and every result has come back.
   task automatic wait_quiet();
      @(negedge clock);
      while (pending_keys.size() != 0 || req_if.valid || expected_entries.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic push_event(input action_type act, input key_type digit,
                             input bit [kmc_pkg::TIME_W-1:0] at_ms);
      key_event_type ev;
      ev.action = act;
      ev.key_number = digit;
      ev.now_ms = at_ms;
      pending_keys.push_back(ev);
      n_queued++;
   endtask

   function automatic action_type pick_toggle();
      case ($urandom_range(0, 2))
         0:       return kmc_pkg::ACT_SHIFT;
         1:       return kmc_pkg::ACT_CAPS;
         default: return kmc_pkg::ACT_SYMBOLS;
      endcase
   endfunction

   // Time step between events: inside the repeat window (sometimes right on its edge)
   // or past it (sometimes just past it).
   function automatic bit [kmc_pkg::TIME_W-1:0] gap_ms(input bit in_window);
      bit on_edge;
      bit [kmc_pkg::TIME_W-1:0] window;
      on_edge = ($urandom_range(0, 9) == 0);
      window = {{(kmc_pkg::TIME_W-kmc_pkg::TMO_W){1'b0}}, ent_timeout};
      if (in_window) return on_edge ? window : $urandom_range(0, window);
      return window + 32'd1 + (on_edge ? 32'd0 : $urandom_range(0, 3000));
   endfunction

   // A run of presses on one key, with the odd toggle mixed in and sometimes a tick after.
   task automatic tap_run();
      key_type digit;
      int presses;
      digit = key_type'($urandom_range(0, 9));
      presses = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 25) : $urandom_range(1, 6);
      if ($urandom_range(0, 3) == 0)
         push_event(pick_toggle(), key_type'($urandom_range(0, 15)), $urandom);
      sim_ms = sim_ms + gap_ms($urandom_range(0, 1) != 0);
      push_event(kmc_pkg::ACT_DIGIT, digit, sim_ms);
      for (int i = 1; i < presses; i++) begin
         sim_ms = sim_ms + gap_ms(presses > 6 || $urandom_range(0, 9) != 0);
         push_event(kmc_pkg::ACT_DIGIT, digit, sim_ms);
         if ($urandom_range(0, 7) == 0)
            push_event(pick_toggle(), key_type'($urandom_range(0, 15)), $urandom);
      end
      if ($urandom_range(0, 2) == 0) begin
         sim_ms = sim_ms + gap_ms($urandom_range(0, 1) != 0);
         push_event(kmc_pkg::ACT_TICK, key_type'($urandom_range(0, 15)), sim_ms);
      end
   endtask

   // Mostly key runs; the rest is toggles, ticks and events with random fields.
   task automatic random_fill(input int count);
      int target;
      int pick;
      target = n_queued + count;
      while (n_queued < target) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            tap_run();
         end else if (pick == 6) begin
            push_event(pick_toggle(), key_type'($urandom_range(0, 15)), $urandom);
         end else if (pick < 9) begin
            sim_ms = sim_ms + gap_ms($urandom_range(0, 1) != 0);
            push_event(kmc_pkg::ACT_TICK, key_type'($urandom_range(0, 15)), sim_ms);
         end else begin
            push_event(action_type'($urandom_range(0, 7)), key_type'($urandom_range(0, 15)),
                       $urandom);
         end
      end
   endtask

   // Stimulus sequence.
   timeout_type timeout_plan[5];

   initial begin
      req_if.valid      = 1'b0;
      req_if.action     = kmc_pkg::ACT_DIGIT;
      req_if.key_number = '0;
      req_if.now_ms     = '0;
      rsp_if.ready      = 1'b0;
      timeout_plan = '{16'd0, 16'hFFFF, 16'd1, 16'd0, kmc_pkg::TIMEOUT_RESET};
      timeout_plan[3] = timeout_type'($urandom_range(2, 65534));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      csr_cycle(1'b0, '0);

      // Directed events under the reset timeout of 1000 ms.
      push_event(kmc_pkg::ACT_TICK, 4'd0, 32'd0);     // tick with nothing pending
      push_event(kmc_pkg::ACT_DIGIT, 4'd2, 32'd100);  // fresh press
      push_event(kmc_pkg::ACT_DIGIT, 4'd2, 32'd600);  // repeat inside the window
      push_event(kmc_pkg::ACT_DIGIT, 4'd2, 32'd1600); // repeat exactly at the deadline
      push_event(kmc_pkg::ACT_DIGIT, 4'd2, 32'd1700); // reaches the digit itself
      push_event(kmc_pkg::ACT_DIGIT, 4'd2, 32'd1800); // wraps to the first letter
      push_event(kmc_pkg::ACT_TICK, 4'd0, 32'd2800);  // tick at the deadline changes nothing
      push_event(kmc_pkg::ACT_SHIFT, 4'd0, 32'd0);
      push_event(kmc_pkg::ACT_TICK, 4'hF, 32'd2801);  // timed out: shift and pending cleared
      push_event(kmc_pkg::ACT_SHIFT, 4'd0, 32'd0);
      push_event(kmc_pkg::ACT_DIGIT, 4'd7, 32'd3000); // first press keeps shift
      push_event(kmc_pkg::ACT_DIGIT, 4'd9, 32'd3100); // other key drops shift
      push_event(kmc_pkg::ACT_CAPS, 4'd0, 32'd0);
      push_event(kmc_pkg::ACT_DIGIT, 4'd9, 32'd3200); // caps without shift
      push_event(kmc_pkg::ACT_SHIFT, 4'd0, 32'd0);
      push_event(kmc_pkg::ACT_DIGIT, 4'd9, 32'd3300); // caps with shift is lower case
      push_event(kmc_pkg::ACT_SYMBOLS, 4'd0, 32'd0);
      push_event(kmc_pkg::ACT_CAPS, 4'd0, 32'd0);     // caps toggle ignored in symbol mode
      push_event(kmc_pkg::ACT_DIGIT, 4'd9, 32'd3400); // symbol mode letter, shift on
      push_event(kmc_pkg::ACT_DIGIT, 4'd1, 32'd3500); // other key leaves symbol mode
      push_event(kmc_pkg::ACT_DIGIT, 4'd10, 32'hFFFF_FFFF); // key above nine is ignored
      push_event(kmc_pkg::ACT_DIGIT, 4'd15, 32'd0);
      push_event(ACT_SPARE_LO, 4'd3, 32'h5555_5555);  // unused action codes are ignored
      push_event(ACT_SPARE_HI, 4'd3, 32'hAAAA_AAAA);
      push_event(kmc_pkg::ACT_DIGIT, 4'd0, 32'hFFFF_FFF0); // deadline wraps past zero
      push_event(kmc_pkg::ACT_DIGIT, 4'd0, 32'h0000_0100); // so this repeat still counts
      wait_quiet();

      // Random phases, each under its own timeout and idling pattern.
      for (int p = 0; p < 5; p++) begin
         tx_idle = (p != 2 && p != 4);
         rx_idle = (p != 1 && p != 4);
         set_timeout(timeout_plan[p]);
         sim_ms = (p == 1) ? 32'hFFFF_F000 : $urandom;
         random_fill(PHASE_ITEMS);
         if (p == 3) begin
            // Receiver stalls while the sender keeps offering, so the block backs up.
            repeat (20) @(negedge clock);
            rx_hold_req = 1'b1;
         end
         wait_quiet();
      end

      repeat (10) @(posedge clock);
      $display("Covered %0d key events (%0d characters, %0d repeat presses) under %0d timeouts.",
               n_sent, n_digits, n_repeats, n_settings + 1);
      $display("Checked %0d result beats; %0d errors.", n_checked, n_errors);
      if (n_errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
